@@ hw/rtl/bdsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bdsc_pkg
// shared types and constants of the box average downscaler
// ----------------------------------------------------------------------------
package bdsc_pkg;

  localparam int PIX_W      = 8;
  localparam int NUM_CH     = 4;
  localparam int SRC_W_W    = 11;
  localparam int SRC_H_W    = 13;
  localparam int DST_W_W    = 11;
  localparam int DST_H_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int DST_X_W    = 10;
  localparam int DST_Y_W    = 12;
  localparam int SIZE_RESET = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 2'd0,
    CFG_SRC_HEIGHT = 2'd1,
    CFG_DST_WIDTH  = 2'd2,
    CFG_DST_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

@@ hw/rtl/bdsc_div.sv @@
// ----------------------------------------------------------------------------
// bdsc_div
// restoring divider, one quotient bit per cycle, msb first
// ----------------------------------------------------------------------------
module bdsc_div #(
  parameter int DEN_W = 11,
  parameter int QUO_W = 11
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DEN_W+QUO_W-1:0]   num,
  input  logic [DEN_W-1:0]         den,
  output logic [QUO_W-1:0]         quot,
  output logic [DEN_W-1:0]         rem,
  output logic                     busy
);
  localparam int XW  = DEN_W + QUO_W;
  localparam int CNW = $clog2(QUO_W + 1);

  logic [XW-1:0]    rem_r;
  logic [XW-1:0]    den_sh_r;
  logic [QUO_W-1:0] quot_r;
  logic [CNW-1:0]   cnt_r;
  logic             busy_r;
  logic             fits;

  assign fits = (rem_r >= den_sh_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNW'(QUO_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNW'(1);
      if (cnt_r == CNW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r    <= num;
      den_sh_r <= XW'(den) << (QUO_W - 1);
      quot_r   <= '0;
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - den_sh_r;
      end
      quot_r   <= {quot_r[QUO_W-2:0], fits};
      den_sh_r <= den_sh_r >> 1;
    end
  end

  assign quot = quot_r;
  assign rem  = rem_r[DEN_W-1:0];
  assign busy = busy_r;

endmodule

@@ hw/rtl/box_average_downscaler_top.sv @@
// ----------------------------------------------------------------------------
// box_average_downscaler_top
// area-average image downscaler over a raster pixel stream
// ----------------------------------------------------------------------------
// Source pixels come in raster order, four 8-bit channels each; every
// destination pixel is the rounded mean of its box of source pixels and is
// sent out, with its position and a frame end flag, on the last source pixel
// of that box. The four channel sums of each destination column live in a
// single-port sum memory (read one cycle, written back the next). A pixel
// that closes a box then starts one bit-serial divider per channel for the
// 8-bit means and waits in S_PUT while the result register is still held.
// After reset and after every configuration write the block divides the
// image sizes for the span steppers; it takes no pixel meanwhile.
// No clearing pass is needed: the first pixel of every box overwrites its sum.
// A finished result sits in an output register while the next pixels are taken.
// ----------------------------------------------------------------------------
module box_average_downscaler_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // pixel request
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [bdsc_pkg::PIX_W-1:0]       in_ch0,
  input  logic [bdsc_pkg::PIX_W-1:0]       in_ch1,
  input  logic [bdsc_pkg::PIX_W-1:0]       in_ch2,
  input  logic [bdsc_pkg::PIX_W-1:0]       in_ch3,
  // result request
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bdsc_pkg::PIX_W-1:0]       out_ch0,
  output logic [bdsc_pkg::PIX_W-1:0]       out_ch1,
  output logic [bdsc_pkg::PIX_W-1:0]       out_ch2,
  output logic [bdsc_pkg::PIX_W-1:0]       out_ch3,
  output logic [bdsc_pkg::DST_X_W-1:0]     out_dst_x,
  output logic [bdsc_pkg::DST_Y_W-1:0]     out_dst_y,
  output logic                             out_frame_end,
  // configuration write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bdsc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bdsc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import bdsc_pkg::*;

  localparam int WW  = $clog2(MAX_WIDTH + 1);   // width sizes
  localparam int HW  = $clog2(MAX_HEIGHT + 1);  // height sizes
  localparam int CW  = $clog2(MAX_WIDTH);       // column index
  localparam int RW  = $clog2(MAX_HEIGHT);      // row index
  localparam int NW  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1); // box pixel count
  localparam int SW  = NW + PIX_W;              // channel sum
  localparam int MW  = NUM_CH * SW;             // memory word

  typedef enum logic [2:0] {
    S_CFG_START,
    S_CFG_WAIT,
    S_IDLE,
    S_RMW,
    S_MEAN_START,
    S_MEAN_WAIT,
    S_PUT
  } state_t;

  state_t state_r;

  // configuration registers
  logic [SRC_W_W-1:0] src_width_r;
  logic [SRC_H_W-1:0] src_height_r;
  logic [DST_W_W-1:0] dst_width_r;
  logic [DST_H_W-1:0] dst_height_r;

  // effective (clamped) sizes
  logic [WW-1:0] sw_nxt, dw_nxt, sw_r, dw_r;
  logic [HW-1:0] sh_nxt, dh_nxt, sh_r, dh_r;

  // span stepping: boundary = q*d + r, advance by s = qs*d + rs
  logic [WW-1:0] qw_r, rw_r;
  logic [HW-1:0] qh_r, rh_r;

  // position state
  logic [CW-1:0] src_col_r, cur_col_r;
  logic [RW-1:0] src_row_r, cur_row_r;
  logic [WW-1:0] col_start_r, col_end_r, col_rem_r;
  logic [HW-1:0] row_start_r, row_end_r, row_rem_r;

  // latched pixel request
  logic [MW-1:0]     pix_r;
  logic [CW-1:0]     idx_r;
  logic              first_r;
  logic              emit_r;
  logic [WW-1:0]     box_w_r;
  logic [HW-1:0]     box_h_r;
  logic [CW-1:0]     ox_r;
  logic [RW-1:0]     oy_r;
  logic              fe_r;

  // sum memory
  logic [MW-1:0] sum_mem [MAX_WIDTH];
  logic [MW-1:0] rd_r;
  logic [MW-1:0] sum_nxt;
  logic [MW-1:0] sum_r;
  logic [NW-1:0] n_r;

  // dividers
  div_ctl_t            cw_ctl, ch_ctl;
  div_ctl_t [NUM_CH-1:0] mean_ctl;
  logic [WW-1:0]       cw_quot, cw_rem;
  logic [HW-1:0]       ch_quot, ch_rem;
  logic [PIX_W-1:0]    mean_quot [NUM_CH];
  logic [NW-1:0]       mean_rem  [NUM_CH];
  logic [SW-1:0]       mean_num  [NUM_CH];
  logic                mean_busy;

  // misc control
  logic in_acc, cfg_acc;
  logic last_col, last_row, row_wrap, frame_wrap;
  logic [WW:0] col_rsum, col_qsum;
  logic [WW-1:0] col_end_nxt, col_rem_nxt;
  logic [HW:0] row_rsum, row_qsum;
  logic [HW-1:0] row_end_nxt, row_rem_nxt;
  logic load_out;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // size clamping: zero acts as one, capped at the maximum or the source
  always_comb begin
    int s_w, s_h, d_w, d_h;
    s_w = int'(src_width_r);
    s_h = int'(src_height_r);
    d_w = int'(dst_width_r);
    d_h = int'(dst_height_r);
    if (s_w == 0) s_w = 1;
    if (s_w > MAX_WIDTH) s_w = MAX_WIDTH;
    if (s_h == 0) s_h = 1;
    if (s_h > MAX_HEIGHT) s_h = MAX_HEIGHT;
    if (d_w == 0) d_w = 1;
    if (d_w > s_w) d_w = s_w;
    if (d_h == 0) d_h = 1;
    if (d_h > s_h) d_h = s_h;
    sw_nxt = WW'(s_w);
    sh_nxt = HW'(s_h);
    dw_nxt = WW'(d_w);
    dh_nxt = HW'(d_h);
  end

  // size ratio dividers, run after reset and after every register write
  assign cw_ctl.start = (state_r == S_CFG_START);
  assign ch_ctl.start = (state_r == S_CFG_START);

  bdsc_div #(.DEN_W(WW), .QUO_W(WW)) u_div_w (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cw_ctl.start),
    .num   ((2*WW)'(sw_nxt)),
    .den   (dw_nxt),
    .quot  (cw_quot),
    .rem   (cw_rem),
    .busy  (cw_ctl.busy)
  );

  bdsc_div #(.DEN_W(HW), .QUO_W(HW)) u_div_h (
    .clk   (clk),
    .rst_n (rst_n),
    .start (ch_ctl.start),
    .num   ((2*HW)'(sh_nxt)),
    .den   (dh_nxt),
    .quot  (ch_quot),
    .rem   (ch_rem),
    .busy  (ch_ctl.busy)
  );

  // next column boundary: add sw/dw, carry the remainder once
  always_comb begin
    col_rsum = (WW+1)'(col_rem_r) + (WW+1)'(rw_r);
    col_qsum = (WW+1)'(col_end_r) + (WW+1)'(qw_r);
    if (col_rsum >= (WW+1)'(dw_r)) begin
      col_rem_nxt = WW'(col_rsum - (WW+1)'(dw_r));
      col_end_nxt = WW'(col_qsum + (WW+1)'(1));
    end else begin
      col_rem_nxt = WW'(col_rsum);
      col_end_nxt = WW'(col_qsum);
    end
  end

  // next row boundary
  always_comb begin
    row_rsum = (HW+1)'(row_rem_r) + (HW+1)'(rh_r);
    row_qsum = (HW+1)'(row_end_r) + (HW+1)'(qh_r);
    if (row_rsum >= (HW+1)'(dh_r)) begin
      row_rem_nxt = HW'(row_rsum - (HW+1)'(dh_r));
      row_end_nxt = HW'(row_qsum + (HW+1)'(1));
    end else begin
      row_rem_nxt = HW'(row_rsum);
      row_end_nxt = HW'(row_qsum);
    end
  end

  assign last_col   = (WW'(src_col_r) + WW'(1) == col_end_r);
  assign last_row   = (HW'(src_row_r) + HW'(1) == row_end_r);
  assign row_wrap   = (WW'(src_col_r) + WW'(1) >= sw_r);
  assign frame_wrap = (HW'(src_row_r) + HW'(1) >= sh_r);

  // read-modify-write of the column sums
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (first_r) begin
        sum_nxt[c*SW +: SW] = SW'(pix_r[c*SW +: SW]);
      end else begin
        sum_nxt[c*SW +: SW] = rd_r[c*SW +: SW] + pix_r[c*SW +: SW];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_r <= sum_mem[cur_col_r];
    end
    if (state_r == S_RMW) begin
      sum_mem[idx_r] <= sum_nxt;
    end
  end

  // mean dividers, one per channel
  assign mean_busy = |{mean_ctl[0].busy, mean_ctl[1].busy,
                       mean_ctl[2].busy, mean_ctl[3].busy};

  for (genvar g = 0; g < NUM_CH; g++) begin : g_mean
    assign mean_ctl[g].start = (state_r == S_MEAN_START);
    // rounded: (sum + n/2) / n
    assign mean_num[g] = sum_r[g*SW +: SW] + SW'(n_r >> 1);

    bdsc_div #(.DEN_W(NW), .QUO_W(PIX_W)) u_div_mean (
      .clk   (clk),
      .rst_n (rst_n),
      .start (mean_ctl[g].start),
      .num   (mean_num[g]),
      .den   (n_r),
      .quot  (mean_quot[g]),
      .rem   (mean_rem[g]),
      .busy  (mean_ctl[g].busy)
    );
  end

  assign load_out = (state_r == S_PUT) && (!out_valid || out_ready);

  // pixel request latch and datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_r   <= {SW'(in_ch3), SW'(in_ch2), SW'(in_ch1), SW'(in_ch0)};
      idx_r   <= cur_col_r;
      first_r <= (HW'(src_row_r) == row_start_r) && (WW'(src_col_r) == col_start_r);
      emit_r  <= last_col && last_row;
      box_w_r <= col_end_r - col_start_r;
      box_h_r <= row_end_r - row_start_r;
      ox_r    <= cur_col_r;
      oy_r    <= cur_row_r;
      fe_r    <= (WW'(cur_col_r) + WW'(1) == dw_r) && (HW'(cur_row_r) + HW'(1) == dh_r);
    end
    if (state_r == S_RMW) begin
      sum_r <= sum_nxt;
      n_r   <= NW'(box_w_r * box_h_r);
    end
    if (load_out) begin
      out_ch0       <= mean_quot[0];
      out_ch1       <= mean_quot[1];
      out_ch2       <= mean_quot[2];
      out_ch3       <= mean_quot[3];
      out_dst_x     <= DST_X_W'(ox_r);
      out_dst_y     <= DST_Y_W'(oy_r);
      out_frame_end <= fe_r;
    end
  end

  // control: state, configuration, position and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CFG_START;
      src_width_r  <= SRC_W_W'(SIZE_RESET);
      src_height_r <= SRC_H_W'(SIZE_RESET);
      dst_width_r  <= DST_W_W'(SIZE_RESET);
      dst_height_r <= DST_H_W'(SIZE_RESET);
      out_valid    <= 1'b0;
      sw_r         <= '0;
      sh_r         <= '0;
      dw_r         <= '0;
      dh_r         <= '0;
      qw_r         <= '0;
      rw_r         <= '0;
      qh_r         <= '0;
      rh_r         <= '0;
      src_col_r    <= '0;
      src_row_r    <= '0;
      cur_col_r    <= '0;
      cur_row_r    <= '0;
      col_start_r  <= '0;
      col_end_r    <= '0;
      col_rem_r    <= '0;
      row_start_r  <= '0;
      row_end_r    <= '0;
      row_rem_r    <= '0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state_r)
        S_CFG_START: begin
          sw_r    <= sw_nxt;
          sh_r    <= sh_nxt;
          dw_r    <= dw_nxt;
          dh_r    <= dh_nxt;
          state_r <= S_CFG_WAIT;
        end
        S_CFG_WAIT: begin
          if (!cw_ctl.busy && !ch_ctl.busy) begin
            // frame restarts at the first source pixel
            qw_r        <= cw_quot;
            rw_r        <= cw_rem;
            qh_r        <= ch_quot;
            rh_r        <= ch_rem;
            src_col_r   <= '0;
            src_row_r   <= '0;
            cur_col_r   <= '0;
            cur_row_r   <= '0;
            col_start_r <= '0;
            col_end_r   <= cw_quot;
            col_rem_r   <= cw_rem;
            row_start_r <= '0;
            row_end_r   <= ch_quot;
            row_rem_r   <= ch_rem;
            state_r     <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            state_r <= S_RMW;
            if (row_wrap) begin
              src_col_r   <= '0;
              cur_col_r   <= '0;
              col_start_r <= '0;
              col_end_r   <= qw_r;
              col_rem_r   <= rw_r;
              if (frame_wrap) begin
                src_row_r   <= '0;
                cur_row_r   <= '0;
                row_start_r <= '0;
                row_end_r   <= qh_r;
                row_rem_r   <= rh_r;
              end else begin
                src_row_r <= src_row_r + RW'(1);
                if (last_row) begin
                  cur_row_r   <= cur_row_r + RW'(1);
                  row_start_r <= row_end_r;
                  row_end_r   <= row_end_nxt;
                  row_rem_r   <= row_rem_nxt;
                end
              end
            end else begin
              src_col_r <= src_col_r + CW'(1);
              if (last_col) begin
                cur_col_r   <= cur_col_r + CW'(1);
                col_start_r <= col_end_r;
                col_end_r   <= col_end_nxt;
                col_rem_r   <= col_rem_nxt;
              end
            end
          end
        end
        S_RMW: begin
          state_r <= emit_r ? S_MEAN_START : S_IDLE;
        end
        S_MEAN_START: begin
          state_r <= S_MEAN_WAIT;
        end
        S_MEAN_WAIT: begin
          if (!mean_busy) begin
            state_r <= S_PUT;
          end
        end
        S_PUT: begin
          if (load_out) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_CFG_START;
      endcase

      // register write: store it and restart the frame
      if (cfg_acc) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SRC_WIDTH:  src_width_r  <= cfg_data[SRC_W_W-1:0];
          CFG_SRC_HEIGHT: src_height_r <= cfg_data[SRC_H_W-1:0];
          CFG_DST_WIDTH:  dst_width_r  <= cfg_data[DST_W_W-1:0];
          CFG_DST_HEIGHT: dst_height_r <= cfg_data[DST_H_W-1:0];
          default: ;
        endcase
        state_r <= S_CFG_START;
      end
    end
  end

endmodule

@@ hw/rtl/bdsc_checker.sv @@
// ----------------------------------------------------------------------------
// bdsc_checker
// port-level checks of the box average downscaler
// ----------------------------------------------------------------------------
module bdsc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [bdsc_pkg::PIX_W-1:0]       out_ch0,
  input logic [bdsc_pkg::DST_X_W-1:0]     out_dst_x,
  input logic                             cfg_valid,
  input logic                             cfg_ready
);
  import bdsc_pkg::*;

  // one pixel at a time: a taken pixel drops ready for the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("pixel taken on back-to-back cycles");

  // a register write restarts setup, no pixel in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |=> !in_ready)
    else $error("pixel taken right after a register write");

  // a stalled result stays
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_ch0) && $stable(out_dst_x)))
    else $error("result changed while stalled");

endmodule

bind box_average_downscaler_top bdsc_checker u_bdsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_ch0   (out_ch0),
  .out_dst_x (out_dst_x),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

@@ verif/box_average_downscaler_top_tb.sv @@
// ----------------------------------------------------------------------------
// box_average_downscaler_top_tb
// self-checking bench for the area-average downscaler
// ----------------------------------------------------------------------------
// Streams raster pixels through the block under several image and box sizes,
// predicts every rounded box mean with a local model of the span logic and the
// per-column sums, and compares each result request field by field. Both
// sides idle at random; size registers change only while the block is idle.
// ----------------------------------------------------------------------------
module box_average_downscaler_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdsc_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 4096;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pix_t in_ch0 = '0, in_ch1 = '0, in_ch2 = '0, in_ch3 = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pix_t out_ch0, out_ch1, out_ch2, out_ch3;
  logic [DST_X_W-1:0] out_dst_x;
  logic [DST_Y_W-1:0] out_dst_y;
  logic out_frame_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_SRC_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  box_average_downscaler_top #(.MAX_WIDTH(MAX_W), .MAX_HEIGHT(MAX_H)) u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_ch0(in_ch0), .in_ch1(in_ch1), .in_ch2(in_ch2), .in_ch3(in_ch3),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_ch0(out_ch0), .out_ch1(out_ch1), .out_ch2(out_ch2), .out_ch3(out_ch3),
    .out_dst_x(out_dst_x), .out_dst_y(out_dst_y), .out_frame_end(out_frame_end),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  typedef struct {
    pix_t               mean [4];
    logic [DST_X_W-1:0] x;
    logic [DST_Y_W-1:0] y;
    logic               frame_end;
  } box_mean_t;

  // expected box means, oldest first
  box_mean_t expected_means [$];
  int unsigned mismatches = 0;

  // local copy of the size registers and the raster walk
  int unsigned reg_sw = SIZE_RESET, reg_sh = SIZE_RESET;
  int unsigned reg_dw = SIZE_RESET, reg_dh = SIZE_RESET;
  int unsigned scol, srow, dcol, drow, cend, rend, rstart;
  longint unsigned col_sum [4][MAX_W];

  // sender burst shaping
  int unsigned burst_left = 0;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int unsigned eff_sw();
    return clamp_size(reg_sw, MAX_W);
  endfunction
  function automatic int unsigned eff_sh();
    return clamp_size(reg_sh, MAX_H);
  endfunction
  function automatic int unsigned eff_dw();
    return clamp_size(reg_dw, eff_sw());
  endfunction
  function automatic int unsigned eff_dh();
    return clamp_size(reg_dh, eff_sh());
  endfunction

  // first source index of destination span i
  function automatic int unsigned span_start(int unsigned i, int unsigned s,
                                             int unsigned d);
    longint unsigned prod;
    prod = longint'(i) * longint'(s);
    return int'(prod / d);
  endfunction

  function automatic void restart_raster();
    scol = 0; srow = 0; dcol = 0; drow = 0; rstart = 0;
    cend = span_start(1, eff_sw(), eff_dw());
    rend = span_start(1, eff_sh(), eff_dh());
  endfunction

  // advance the raster walk by one pixel and queue a mean when a box closes
  function automatic void predict_box_mean(pix_t p [4]);
    int unsigned sw, sh, dw, dh, idx, cstart;
    bit last_col, last_row;
    longint unsigned n;
    box_mean_t r;
    sw = eff_sw(); sh = eff_sh(); dw = eff_dw(); dh = eff_dh();
    idx = dcol;
    cstart = span_start(idx, sw, dw);
    last_col = (scol + 1 == cend);
    last_row = (srow + 1 == rend);
    if (idx >= MAX_W) idx = MAX_W - 1;
    // first pixel of a box overwrites the column sum
    for (int c = 0; c < 4; c++)
      if (srow == rstart && scol == cstart) col_sum[c][idx] = p[c];
      else col_sum[c][idx] += p[c];
    if (last_col && last_row) begin
      n = longint'(cend - cstart) * longint'(rend - rstart);
      for (int c = 0; c < 4; c++)
        r.mean[c] = (n == 0) ? '0 : pix_t'((col_sum[c][idx] + n / 2) / n);
      r.x = dcol[DST_X_W-1:0];
      r.y = drow[DST_Y_W-1:0];
      r.frame_end = (dcol + 1 == dw) && (drow + 1 == dh);
      expected_means.push_back(r);
    end
    if (scol + 1 >= sw) begin
      scol = 0; dcol = 0;
      cend = span_start(1, sw, dw);
      if (srow + 1 >= sh) begin
        restart_raster();
      end else begin
        if (last_row) begin
          drow++;
          rstart = rend;
          rend = span_start(drow + 1, sh, dh);
        end
        srow++;
      end
    end else begin
      scol++;
      if (last_col) begin
        dcol++;
        cend = span_start(dcol + 1, sw, dw);
      end
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    box_mean_t e;
    pix_t got [4];
    if (rst_n && out_valid && out_ready) begin
      if (expected_means.size() == 0) begin
        $error("unexpected result request at x=%0d y=%0d", out_dst_x, out_dst_y);
        mismatches++;
      end else begin
        e = expected_means.pop_front();
        got[0] = out_ch0; got[1] = out_ch1; got[2] = out_ch2; got[3] = out_ch3;
        for (int c = 0; c < 4; c++)
          if (got[c] !== e.mean[c]) begin
            $error("out_ch%0d expected %0d got %0d", c, e.mean[c], got[c]);
            mismatches++;
          end
        if (out_dst_x !== e.x) begin
          $error("out_dst_x expected %0d got %0d", e.x, out_dst_x);
          mismatches++;
        end
        if (out_dst_y !== e.y) begin
          $error("out_dst_y expected %0d got %0d", e.y, out_dst_y);
          mismatches++;
        end
        if (out_frame_end !== e.frame_end) begin
          $error("out_frame_end expected %0d got %0d", e.frame_end, out_frame_end);
          mismatches++;
        end
      end
    end
  end

  // receiver stall pattern: modes of always ready, coin flip and long stalls
  int unsigned stall_mode = 0, stall_cnt = 0;
  always @(posedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_cnt  <= $urandom_range(20, 120);
    end else begin
      stall_cnt <= stall_cnt - 1;
    end
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      default: out_ready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // send one pixel request; called at a rising edge, returns at its acceptance
  task automatic send_pixel(pix_t c0, pix_t c1, pix_t c2, pix_t c3);
    int unsigned gap;
    pix_t p [4];
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_ch0 <= c0; in_ch1 <= c1; in_ch2 <= c2; in_ch3 <= c3;
    do @(posedge clk); while (!in_ready);
    p[0] = c0; p[1] = c1; p[2] = c2; p[3] = c3;
    predict_box_mean(p);
  endtask

  task automatic send_random_pixel();
    send_pixel($urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 255));
  endtask

  // hold the sender until every expected mean has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_means.size() != 0) @(posedge clk);
  endtask

  // idle the block, then write one size register
  task automatic write_size(cfg_idx_t idx, int unsigned value);
    wait_drained();
    // a pixel that closes no box may still be in flight
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SRC_WIDTH:  reg_sw = value & 'h7FF;
      CFG_SRC_HEIGHT: reg_sh = value & 'h1FFF;
      CFG_DST_WIDTH:  reg_dw = value & 'h7FF;
      default:        reg_dh = value & 'h1FFF;
    endcase
    restart_raster();
  endtask

  task automatic set_sizes(int unsigned sw, int unsigned sh, int unsigned dw,
                           int unsigned dh);
    write_size(CFG_SRC_WIDTH, sw);
    write_size(CFG_SRC_HEIGHT, sh);
    write_size(CFG_DST_WIDTH, dw);
    write_size(CFG_DST_HEIGHT, dh);
  endtask

  // reset sizes are identity, then a 4x4 frame into 2x2 boxes with rounding
  // edges, destination clamping, and the wrap into a second frame
  task automatic test_directed();
    for (int i = 0; i < 3; i++) send_pixel(8'h00, 8'hFF, 8'h55, 8'hAA);
    set_sizes(4, 4, 2, 2);
    for (int i = 0; i < 16; i++)
      case (i % 4)
        0: send_pixel(8'hFF, 8'h00, 8'h01, 8'h02);
        1: send_pixel(8'hFF, 8'h00, 8'h00, 8'h00);
        2: send_pixel(8'hFF, 8'h00, 8'h00, 8'h00);
        default: send_pixel(8'hFF, 8'h00, 8'h01, 8'h00);
      endcase
    // growing request acts as identity
    set_sizes(3, 2, 1000, 4000);
    for (int i = 0; i < 8; i++) send_random_pixel();
  endtask

  // widest source row: 256-pixel boxes, one closed, the row left partial
  task automatic test_wide_row();
    set_sizes(MAX_W, 1, 4, 1);
    for (int i = 0; i < 400; i++) send_random_pixel();
  endtask

  // tallest source column: 128-row boxes, one closed
  task automatic test_tall_column();
    set_sizes(1, MAX_H, 1, 32);
    for (int i = 0; i < 150; i++) send_random_pixel();
    // a partial frame left behind by a size change
    write_size(CFG_DST_HEIGHT, 3);
    for (int i = 0; i < 20; i++) send_random_pixel();
  endtask

  // random small frames, mostly whole, some cut short by a size change
  task automatic test_random_frames();
    int unsigned sw, sh, dw, dh, npix, sent;
    sent = 0;
    while (sent < 350) begin
      sw = $urandom_range(1, 12);
      sh = $urandom_range(1, 8);
      dw = $urandom_range(1, sw + 2);
      dh = $urandom_range(1, sh + 2);
      set_sizes(sw, sh, dw, dh);
      npix = sw * sh * $urandom_range(1, 3);
      if ($urandom_range(0, 4) == 0) npix = $urandom_range(1, sw * sh);
      if (npix > 350 - sent) npix = 350 - sent;
      for (int i = 0; i < npix; i++) begin
        send_random_pixel();
        // mid-frame hold-off until the result side has caught up
        if ($urandom_range(0, 199) == 0) wait_drained();
      end
      sent += npix;
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    restart_raster();
    @(posedge clk);
    test_directed();
    test_wide_row();
    test_tall_column();
    test_random_frames();
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/bdsc_pkg.sv
hw/rtl/bdsc_div.sv
hw/rtl/box_average_downscaler_top.sv
hw/rtl/bdsc_checker.sv
verif/box_average_downscaler_top_tb.sv
